// File: hdl/titl_pkg.sv
`default_nettype none
package titl_pkg;

   localparam int DEPTH_DEF     = 64;
   localparam int TIME_BITS_DEF = 32;
   localparam int TAG_BITS_DEF  = 16;
   localparam int INDEX_BITS    = 6;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_INS_SCAN = 5'b00010,
      ST_INS_PUT  = 5'b00100,
      ST_LKP_SCAN = 5'b01000,
      ST_FINISH   = 5'b10000
   } state_type;

   typedef struct packed {
      logic covers;
      logic start_gt;
   } cmp_type;

endpackage
`default_nettype wire

// File: hdl/titl_ram.sv
`default_nettype none
module titl_ram #(
   parameter int WIDTH = titl_pkg::TIME_BITS_DEF,
   parameter int DEPTH = titl_pkg::DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hdl/titl_cmp.sv
`default_nettype none
module titl_cmp #(
   parameter int TIME_BITS = titl_pkg::TIME_BITS_DEF
) (
   input  wire logic [TIME_BITS-1:0] entry_start,
   input  wire logic [TIME_BITS-1:0] entry_end,
   input  wire logic [TIME_BITS-1:0] key,
   output titl_pkg::cmp_type         result
);

   // interval is [start, end)
   always_comb begin
      result.start_gt = entry_start > key;
      result.covers   = (entry_start <= key) && (entry_end > key);
   end

endmodule
`default_nettype wire

// File: hdl/titl_seq.sv
`default_nettype none
module titl_seq #(
   parameter int DEPTH     = titl_pkg::DEPTH_DEF,
   parameter int TIME_BITS = titl_pkg::TIME_BITS_DEF,
   parameter int TAG_BITS  = titl_pkg::TAG_BITS_DEF,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1),
   localparam int EW = 2 * TIME_BITS + TAG_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_kind,
   input  wire logic [TIME_BITS-1:0]  req_start_time,
   input  wire logic [TIME_BITS-1:0]  req_end_time,
   input  wire logic [TAG_BITS-1:0]   req_tag,
   input  wire logic [TIME_BITS-1:0]  req_query_time,
   output logic                       idle,
   input  wire logic                  out_free,
   output logic                       res_load,
   output logic [1:0]                 res_status,
   output logic [titl_pkg::INDEX_BITS-1:0] res_index,
   output logic [TAG_BITS-1:0]        res_tag,
   output logic [TIME_BITS-1:0]       res_start,
   output logic [TIME_BITS-1:0]       res_end,
   output logic                       ram_wr_en,
   output logic [AW-1:0]              ram_wr_addr,
   output logic [EW-1:0]              ram_wr_data,
   output logic [AW-1:0]              ram_rd_addr,
   input  wire logic [EW-1:0]         ram_rd_data,
   output logic [TIME_BITS-1:0]       cmp_key,
   input  wire titl_pkg::cmp_type     cmp_res
);

   titl_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        cursor_ff, cursor_in;
   logic                 cursor_valid_ff, cursor_valid_in;
   logic [TIME_BITS-1:0] prev_query_ff, prev_query_in;
   logic [AW-1:0]        data_addr_ff, data_addr_in;
   logic                 fwd_ff, fwd_in;
   logic [TIME_BITS-1:0] key_ff, key_in;
   logic [TIME_BITS-1:0] new_end_ff, new_end_in;
   logic [TAG_BITS-1:0]  new_tag_ff, new_tag_in;
   titl_pkg::status_type res_status_ff, res_status_in;
   logic [AW-1:0]        res_index_ff, res_index_in;
   logic [TAG_BITS-1:0]  res_tag_ff, res_tag_in;
   logic [TIME_BITS-1:0] res_start_ff, res_start_in;
   logic [TIME_BITS-1:0] res_end_ff, res_end_in;
   logic                 have_cursor;
   logic                 last_entry;

   assign have_cursor = cursor_valid_ff && (CW'(cursor_ff) < count_ff);
   assign last_entry  = CW'(data_addr_ff) == (count_ff - CW'(1));

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      cursor_in       = cursor_ff;
      cursor_valid_in = cursor_valid_ff;
      prev_query_in   = prev_query_ff;
      data_addr_in    = data_addr_ff;
      fwd_in          = fwd_ff;
      key_in          = key_ff;
      new_end_in      = new_end_ff;
      new_tag_in      = new_tag_ff;
      res_status_in   = res_status_ff;
      res_index_in    = res_index_ff;
      res_tag_in      = res_tag_ff;
      res_start_in    = res_start_ff;
      res_end_in      = res_end_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = '0;
      ram_wr_data     = '0;
      ram_rd_addr     = data_addr_ff;
      res_load        = 1'b0;

      case (state_ff)
         titl_pkg::ST_IDLE: begin
            if (req_valid) begin
               res_status_in = titl_pkg::STATUS_OK;
               res_index_in  = '0;
               res_tag_in    = '0;
               res_start_in  = '0;
               res_end_in    = '0;
               if (!req_kind) begin
                  if (count_ff == CW'(DEPTH)) begin
                     res_status_in = titl_pkg::STATUS_FULL;
                     state_in      = titl_pkg::ST_FINISH;
                  end else begin
                     cursor_valid_in = 1'b0;
                     key_in          = req_start_time;
                     new_end_in      = req_end_time;
                     new_tag_in      = req_tag;
                     if (count_ff == '0) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = {req_tag, req_end_time, req_start_time};
                        count_in    = count_ff + CW'(1);
                        state_in    = titl_pkg::ST_FINISH;
                     end else begin
                        ram_rd_addr  = AW'(count_ff - CW'(1));
                        data_addr_in = AW'(count_ff - CW'(1));
                        state_in     = titl_pkg::ST_INS_SCAN;
                     end
                  end
               end else begin
                  prev_query_in = req_query_time;
                  key_in        = req_query_time;
                  if (have_cursor) begin
                     ram_rd_addr  = cursor_ff;
                     data_addr_in = cursor_ff;
                     fwd_in       = prev_query_ff < req_query_time;
                     state_in     = titl_pkg::ST_LKP_SCAN;
                  end else if (count_ff == '0) begin
                     res_status_in   = titl_pkg::STATUS_MISS;
                     cursor_valid_in = 1'b0;
                     state_in        = titl_pkg::ST_FINISH;
                  end else begin
                     ram_rd_addr  = '0;
                     data_addr_in = '0;
                     fwd_in       = 1'b1;
                     state_in     = titl_pkg::ST_LKP_SCAN;
                  end
               end
            end
         end
         titl_pkg::ST_INS_SCAN: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = data_addr_ff + AW'(1);
            if (cmp_res.start_gt) begin
               // move entry up one slot
               ram_wr_data = ram_rd_data;
               if (data_addr_ff == '0) begin
                  state_in = titl_pkg::ST_INS_PUT;
               end else begin
                  ram_rd_addr  = data_addr_ff - AW'(1);
                  data_addr_in = data_addr_ff - AW'(1);
               end
            end else begin
               ram_wr_data  = {new_tag_ff, new_end_ff, key_ff};
               count_in     = count_ff + CW'(1);
               res_index_in = data_addr_ff + AW'(1);
               state_in     = titl_pkg::ST_FINISH;
            end
         end
         titl_pkg::ST_INS_PUT: begin
            ram_wr_en    = 1'b1;
            ram_wr_data  = {new_tag_ff, new_end_ff, key_ff};
            count_in     = count_ff + CW'(1);
            res_index_in = '0;
            state_in     = titl_pkg::ST_FINISH;
         end
         titl_pkg::ST_LKP_SCAN: begin
            if (cmp_res.covers) begin
               res_index_in    = data_addr_ff;
               res_start_in    = ram_rd_data[TIME_BITS-1:0];
               res_end_in      = ram_rd_data[2*TIME_BITS-1:TIME_BITS];
               res_tag_in      = ram_rd_data[EW-1:2*TIME_BITS];
               cursor_in       = data_addr_ff;
               cursor_valid_in = 1'b1;
               state_in        = titl_pkg::ST_FINISH;
            end else if (fwd_ff ? (cmp_res.start_gt || last_entry)
                                : (data_addr_ff == '0)) begin
               res_status_in   = titl_pkg::STATUS_MISS;
               cursor_valid_in = 1'b0;
               state_in        = titl_pkg::ST_FINISH;
            end else if (fwd_ff) begin
               ram_rd_addr  = data_addr_ff + AW'(1);
               data_addr_in = data_addr_ff + AW'(1);
            end else begin
               ram_rd_addr  = data_addr_ff - AW'(1);
               data_addr_in = data_addr_ff - AW'(1);
            end
         end
         titl_pkg::ST_FINISH: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = titl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = titl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= titl_pkg::ST_IDLE;
         count_ff        <= '0;
         cursor_ff       <= '0;
         cursor_valid_ff <= 1'b0;
         prev_query_ff   <= '0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         cursor_ff       <= cursor_in;
         cursor_valid_ff <= cursor_valid_in;
         prev_query_ff   <= prev_query_in;
      end
   end

   always_ff @(posedge clock) begin
      data_addr_ff  <= data_addr_in;
      fwd_ff        <= fwd_in;
      key_ff        <= key_in;
      new_end_ff    <= new_end_in;
      new_tag_ff    <= new_tag_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_tag_ff    <= res_tag_in;
      res_start_ff  <= res_start_in;
      res_end_ff    <= res_end_in;
   end

   assign idle       = state_ff == titl_pkg::ST_IDLE;
   assign cmp_key    = key_ff;
   assign res_status = res_status_ff;
   assign res_index  = titl_pkg::INDEX_BITS'(res_index_ff);
   assign res_tag    = res_tag_ff;
   assign res_start  = res_start_ff;
   assign res_end    = res_end_ff;

endmodule
`default_nettype wire

// File: hdl/timed_interval_table_lookup.sv
// Accept to result: an insert into an empty table writes at once, one into a full one is
//   refused; other inserts move larger entries up, lookups scan from cursor or slot zero.
// A new word is taken only after the last one's result is loaded into the result register.
// The result register frees the sequencer once the result is taken or the slot is empty.
// Reset clears entry count, cursor and previous query; RAM contents are not cleared.
`default_nettype none
module timed_interval_table_lookup #(
   parameter int DEPTH     = titl_pkg::DEPTH_DEF,
   parameter int TIME_BITS = titl_pkg::TIME_BITS_DEF,
   parameter int TAG_BITS  = titl_pkg::TAG_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_kind,
   input  wire logic [TIME_BITS-1:0]          req_start_time,
   input  wire logic [TIME_BITS-1:0]          req_end_time,
   input  wire logic [TAG_BITS-1:0]           req_tag,
   input  wire logic [TIME_BITS-1:0]          req_query_time,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [titl_pkg::INDEX_BITS-1:0]    rsp_index,
   output logic [TAG_BITS-1:0]                rsp_found_tag,
   output logic [TIME_BITS-1:0]               rsp_found_start,
   output logic [TIME_BITS-1:0]               rsp_found_end
);

   localparam int AW = $clog2(DEPTH);
   localparam int EW = 2 * TIME_BITS + TAG_BITS;

   logic                 idle;
   logic                 out_free;
   logic                 res_load;
   logic [1:0]           res_status;
   logic [titl_pkg::INDEX_BITS-1:0] res_index;
   logic [TAG_BITS-1:0]  res_tag;
   logic [TIME_BITS-1:0] res_start;
   logic [TIME_BITS-1:0] res_end;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [EW-1:0]        ram_wr_data;
   logic [AW-1:0]        ram_rd_addr;
   logic [EW-1:0]        ram_rd_data;
   logic [TIME_BITS-1:0] cmp_key;
   titl_pkg::cmp_type    cmp_res;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff;
   logic [titl_pkg::INDEX_BITS-1:0] rsp_index_ff;
   logic [TAG_BITS-1:0]  rsp_tag_ff;
   logic [TIME_BITS-1:0] rsp_start_ff;
   logic [TIME_BITS-1:0] rsp_end_ff;

   titl_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   titl_cmp #(
      .TIME_BITS (TIME_BITS)
   ) u_cmp (
      .entry_start (ram_rd_data[TIME_BITS-1:0]),
      .entry_end   (ram_rd_data[2*TIME_BITS-1:TIME_BITS]),
      .key         (cmp_key),
      .result      (cmp_res)
   );

   titl_seq #(
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS),
      .TAG_BITS  (TAG_BITS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_kind       (req_kind),
      .req_start_time (req_start_time),
      .req_end_time   (req_end_time),
      .req_tag        (req_tag),
      .req_query_time (req_query_time),
      .idle           (idle),
      .out_free       (out_free),
      .res_load       (res_load),
      .res_status     (res_status),
      .res_index      (res_index),
      .res_tag        (res_tag),
      .res_start      (res_start),
      .res_end        (res_end),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .cmp_key        (cmp_key),
      .cmp_res        (cmp_res)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !idle;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_status_ff <= res_status;
         rsp_index_ff  <= res_index;
         rsp_tag_ff    <= res_tag;
         rsp_start_ff  <= res_start;
         rsp_end_ff    <= res_end;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_index       = rsp_index_ff;
   assign rsp_found_tag   = rsp_tag_ff;
   assign rsp_found_start = rsp_start_ff;
   assign rsp_found_end   = rsp_end_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block took a word but did not go busy");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(res_load && rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == titl_pkg::STATUS_FULL) |->
      (rsp_index_ff == '0 && rsp_tag_ff == '0 && rsp_start_ff == '0 && rsp_end_ff == '0))
      else $error("full response carries nonzero fields");

endmodule
`default_nettype wire

// File: verif/timed_interval_table_lookup_tb.sv
`default_nettype none
module timed_interval_table_lookup_tb;

   localparam int DEPTH = titl_pkg::DEPTH_DEF;
   localparam int TW = titl_pkg::TIME_BITS_DEF;
   localparam int GW = titl_pkg::TAG_BITS_DEF;
   localparam int IW = titl_pkg::INDEX_BITS;
   localparam int RANDOM_WORDS = 630;
   localparam int MAX_REPORTS = 10;
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   typedef struct packed {
      logic          kind;
      logic [TW-1:0] start_time;
      logic [TW-1:0] end_time;
      logic [GW-1:0] tag;
      logic [TW-1:0] query_time;
   } req_word_type;

   typedef struct packed {
      titl_pkg::status_type status;
      logic [IW-1:0]        index;
      logic [GW-1:0]        found_tag;
      logic [TW-1:0]        found_start;
      logic [TW-1:0]        found_end;
   } rsp_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_kind = 1'b0;
   logic [TW-1:0]         req_start_time = '0;
   logic [TW-1:0]         req_end_time = '0;
   logic [GW-1:0]         req_tag = '0;
   logic [TW-1:0]         req_query_time = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_status;
   logic [IW-1:0]         rsp_index;
   logic [GW-1:0]         rsp_found_tag;
   logic [TW-1:0]         rsp_found_start;
   logic [TW-1:0]         rsp_found_end;

   timed_interval_table_lookup #(
      .DEPTH(DEPTH),
      .TIME_BITS(TW),
      .TAG_BITS(GW)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_start_time(req_start_time),
      .req_end_time(req_end_time),
      .req_tag(req_tag),
      .req_query_time(req_query_time),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_index(rsp_index),
      .rsp_found_tag(rsp_found_tag),
      .rsp_found_start(rsp_found_start),
      .rsp_found_end(rsp_found_end)
   );

   always #6 clock = ~clock;

   // shadow interval table
   logic [TW-1:0] tbl_start [DEPTH];
   logic [TW-1:0] tbl_end [DEPTH];
   logic [GW-1:0] tbl_tag [DEPTH];
   int            tbl_count = 0;
   int            cur_slot = 0;
   bit            cur_ok = 1'b0;
   logic [TW-1:0] last_query = '0;

   int n_placed = 0, n_full = 0, n_hit = 0, n_miss = 0;
   int n_cursor = 0, n_fwd = 0, n_back = 0, n_zero = 0;

   req_word_type pending_q[$];
   rsp_word_type expected_q[$];
   req_word_type cur_word;
   rsp_word_type want_word;
   int        total_words = 0;
   int        words_taken = 0;
   int        mismatches = 0;
   int        burst_left = 8;
   int        gap_left = 0;
   int        stall_cyc = 0;

   // generator-side view of inserted intervals
   logic [TW-1:0] gen_start [$];
   logic [TW-1:0] gen_end [$];
   logic [TW-1:0] gen_prev = '0;

   function automatic bit covers(int slot, logic [TW-1:0] q);
      return tbl_start[slot] <= q && tbl_end[slot] > q;
   endfunction

   function automatic int scan_up(int from, logic [TW-1:0] q);
      int i;
      for (i = from; i < tbl_count; i++) begin
         if (covers(i, q))
            return i;
         if (tbl_start[i] > q)
            return -1;
      end
      return -1;
   endfunction

   function automatic rsp_word_type apply_word(req_word_type w);
      rsp_word_type r;
      int        pos;
      int        slot;
      int        i;
      bit        have;
      r = '0;
      r.status = titl_pkg::STATUS_OK;
      if (w.kind == KIND_INSERT) begin
         if (tbl_count >= DEPTH) begin
            r.status = titl_pkg::STATUS_FULL;
            n_full++;
            return r;
         end
         pos = 0;
         while (pos < tbl_count && tbl_start[pos] <= w.start_time)
            pos++;
         for (i = tbl_count; i > pos; i--) begin
            tbl_start[i] = tbl_start[i-1];
            tbl_end[i] = tbl_end[i-1];
            tbl_tag[i] = tbl_tag[i-1];
         end
         tbl_start[pos] = w.start_time;
         tbl_end[pos] = w.end_time;
         tbl_tag[pos] = w.tag;
         tbl_count++;
         cur_ok = 1'b0;
         r.index = pos[IW-1:0];
         n_placed++;
         return r;
      end
      have = cur_ok && cur_slot < tbl_count;
      slot = -1;
      if (have && covers(cur_slot, w.query_time)) begin
         slot = cur_slot;
         n_cursor++;
      end else if (have && last_query < w.query_time) begin
         slot = scan_up(cur_slot, w.query_time);
         n_fwd++;
      end else if (!have) begin
         slot = scan_up(0, w.query_time);
         n_zero++;
      end else begin
         n_back++;
         for (i = cur_slot; i >= 0; i--) begin
            if (covers(i, w.query_time)) begin
               slot = i;
               break;
            end
         end
      end
      last_query = w.query_time;
      if (slot >= 0) begin
         cur_slot = slot;
         cur_ok = 1'b1;
         r.index = slot[IW-1:0];
         r.found_tag = tbl_tag[slot];
         r.found_start = tbl_start[slot];
         r.found_end = tbl_end[slot];
         n_hit++;
      end else begin
         cur_ok = 1'b0;
         r.status = titl_pkg::STATUS_MISS;
         n_miss++;
      end
      return r;
   endfunction

   function automatic void add_insert(logic [TW-1:0] s, logic [TW-1:0] e, logic [GW-1:0] g);
      req_word_type w;
      w.kind = KIND_INSERT;
      w.start_time = s;
      w.end_time = e;
      w.tag = g;
      w.query_time = $urandom;
      pending_q.push_back(w);
      total_words++;
      if (gen_start.size() < DEPTH) begin
         gen_start.push_back(s);
         gen_end.push_back(e);
      end
   endfunction

   function automatic void add_lookup(logic [TW-1:0] q);
      req_word_type w;
      w.kind = KIND_LOOKUP;
      w.start_time = $urandom;
      w.end_time = $urandom;
      w.tag = $urandom;
      w.query_time = q;
      pending_q.push_back(w);
      total_words++;
      gen_prev = q;
   endfunction

   // sender: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_q.push_back(apply_word(cur_word));
            words_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               cur_word = pending_q.pop_front();
               req_kind <= cur_word.kind;
               req_start_time <= cur_word.start_time;
               req_end_time <= cur_word.end_time;
               req_tag <= cur_word.tag;
               req_query_time <= cur_word.query_time;
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern rotates among four modes
   always @(posedge clock) begin
      stall_cyc <= stall_cyc + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case ((stall_cyc / 400) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= ((stall_cyc % 5) < 2);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: result word with none expected: status %0d index %0d",
                        rsp_status, rsp_index);
         end else begin
            want_word = expected_q.pop_front();
            if (rsp_status !== want_word.status || rsp_index !== want_word.index ||
                rsp_found_tag !== want_word.found_tag ||
                rsp_found_start !== want_word.found_start ||
                rsp_found_end !== want_word.found_end) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("ERROR: expected status %0d index %0d tag %h start %h end %h",
                           want_word.status, want_word.index, want_word.found_tag,
                           want_word.found_start, want_word.found_end);
                  $display("       actual   status %0d index %0d tag %h start %h end %h",
                           rsp_status, rsp_index, rsp_found_tag, rsp_found_start,
                           rsp_found_end);
               end
            end
         end
      end
   end

   initial begin
      #(12 * 1_000_000);
      $display("ERROR: timed out with %0d results outstanding", expected_q.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int            n;
      int            k;
      logic [TW-1:0] s;
      logic [TW-1:0] e;
      logic [TW-1:0] q;

      // directed: empty table, edge values, equal starts, every lookup path
      add_lookup('0);
      add_insert('0, '0, '0);
      add_lookup('0);
      add_insert('1, '1, '1);
      add_insert(100, 200, 1);
      add_insert(100, 300, 2);
      add_insert(50, 150, 3);
      add_insert(400, 350, 4);
      add_lookup(120);
      add_lookup(130);
      add_lookup(250);
      add_lookup(60);
      add_lookup(60);
      add_lookup(370);
      add_lookup(180);
      add_lookup(10);
      add_lookup('1);
      add_insert(32'hFFFF_FFFE, 32'hFFFF_FFFF, 16'hAAAA);
      add_lookup(32'hFFFF_FFFE);
      add_lookup(150);
      add_lookup(200);
      add_insert(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
      add_lookup(32'h6000_0000);

      for (n = 0; n < RANDOM_WORDS; n++) begin
         if ($urandom_range(0, 99) < 15) begin
            case ($urandom_range(0, 9))
               0: s = $urandom;
               1: s = gen_start[$urandom_range(0, gen_start.size() - 1)];
               2: s = 32'hFFFF_F000 + $urandom_range(0, 32'hFFF);
               default: s = $urandom_range(0, 2000);
            endcase
            case ($urandom_range(0, 9))
               0: e = s - $urandom_range(0, 5);
               1: e = $urandom;
               default: e = s + $urandom_range(1, 300);
            endcase
            add_insert(s, e, $urandom);
         end else begin
            k = $urandom_range(0, gen_start.size() - 1);
            case ($urandom_range(0, 19))
               0, 1, 2: q = gen_prev + $urandom_range(1, 60);
               3, 4, 5: q = gen_prev - $urandom_range(0, 60);
               6: q = gen_end[k];
               7: q = gen_start[k] - 1;
               8: q = $urandom;
               9, 10: q = $urandom_range(0, 2500);
               default: begin
                  if (gen_end[k] > gen_start[k])
                     q = gen_start[k] + $urandom_range(0, gen_end[k] - gen_start[k] - 1);
                  else
                     q = gen_start[k];
               end
            endcase
            add_lookup(q);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (words_taken < total_words || expected_q.size() != 0)
         @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
      if (expected_q.size() != 0)
         mismatches++;

      $display("Ran %0d words: %0d inserts placed, %0d refused on a full table,",
               total_words, n_placed, n_full);
      $display("  %0d hits, %0d misses; lookup paths: %0d cursor hits, %0d forward, %0d backward, %0d from slot zero",
               n_hit, n_miss, n_cursor, n_fwd, n_back, n_zero);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatched words", mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
